// ----- design/bfrc_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the multidrop frame receiver.
`timescale 1ns / 1ps

package bfrc_pkg;

   // Fixed field widths
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int LEN_W    = 4;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_MASK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // Configuration reset values
   localparam logic [BYTE_W-1:0] OWN_ID_RST        = 8'h01;
   localparam logic [BYTE_W-1:0] GROUP_MASK_RST    = 8'h00;
   localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RST = 8'h40;

   // Frame constants
   localparam logic [BYTE_W-1:0] ATTR_KIND_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] ATTR_FEEDBACK  = 8'h80;
   localparam logic [BYTE_W-1:0] ATTR_GROUP_BIT = 8'h10;
   localparam logic [BYTE_W-1:0] ATTR_LEN_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] BROADCAST_ID   = 8'h03;
   localparam logic [BYTE_W-1:0] GROUP_ID_MAX   = 8'h08;
   localparam logic [BYTE_W-1:0] CRC_POLY_REFL  = 8'h8C;

   // Frame positions (byte_count values)
   localparam logic [COUNT_W-1:0] POS_ATTR     = 5'd2;
   localparam logic [COUNT_W-1:0] POS_CRC_ONLY = 5'd3;
   localparam logic [COUNT_W-1:0] POS_DEST     = 5'd4;
   localparam logic [COUNT_W-1:0] HDR_BYTES    = 5'd5;
   localparam logic [COUNT_W-1:0] STORE_SKIP   = 5'd2;
   localparam logic [COUNT_W-1:0] STORED_HDR   = 5'd3;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // input transaction taken this cycle
      logic emit_load;  // load next stored byte into the result register
   } bfrc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic frame_good; // offered byte closes a frame with matching CRC
      logic frame_bad;  // offered byte closes a frame with CRC mismatch
      logic emit_last;  // next emitted byte is the last of the run
   } bfrc_sts_type;

   // One byte through the reflected CRC-8 (Maxim), bit by bit
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/bus_frame_receiver_crc8_unit.sv -----
// Top level of the multidrop 9-bit frame receiver with CRC-8 check.
// Throughput: one request transaction per cycle while idle and the result register is free.
// Results: an error result shows in the cycle after the CRC byte; a good frame's run
//   starts in the emit state and gives PAYLOAD_MAX+3 results at most, one per cycle as taken,
//   set by the single read port of the frame store. No request is taken during the run.
// Reset: synchronous, clears parser and handshake state, loads own_id 1, group_mask 0,
//   timeout_ticks 64; the frame store is not cleared.
`timescale 1ns / 1ps

module bus_frame_receiver_crc8_unit
   import bfrc_pkg::*;
#(
   parameter int PAYLOAD_MAX = 15
)(
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   // Request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   input  logic [1:0]           req_tuser,   // [0] func, [1] ninth_bit
   // Result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [7:0] data_byte, [12:8] byte_index,
                                             // [13] send_ack, [14] group_addressed,
                                             // [22:15] group_id, [23] zero
   output logic                 rsp_tlast,   // last_byte
   output logic [0:0]           rsp_tuser    // [0] frame_ok
);

   bfrc_cmd_type       cmd;
   bfrc_sts_type       sts;
   logic [BYTE_W-1:0]  data_byte, group_id;
   logic [COUNT_W-1:0] byte_index;
   logic               last_byte, frame_ok, send_ack, group_addressed;

   // Sequencing: take bytes when idle, step through the stored run when a frame passes
   bfrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Parser, CRC, timeout, frame store and result register
   bfrc_datapath #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .in_func             (req_tuser[0]),
      .in_rx_byte          (req_tdata),
      .in_ninth_bit        (req_tuser[1]),
      .cmd                 (cmd),
      .sts                 (sts),
      .out_data_byte       (data_byte),
      .out_byte_index      (byte_index),
      .out_last_byte       (last_byte),
      .out_frame_ok        (frame_ok),
      .out_send_ack        (send_ack),
      .out_group_addressed (group_addressed),
      .out_group_id        (group_id)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {1'b0, group_id, group_addressed, send_ack, byte_index, data_byte};
   assign rsp_tlast = last_byte;
   assign rsp_tuser = frame_ok;

endmodule

// ----- design/bfrc_ctrl.sv -----
// Controller: accepts bytes while idle and paces the run of stored bytes to the output.
`timescale 1ns / 1ps

module bfrc_ctrl
   import bfrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  bfrc_sts_type sts,
   output bfrc_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd.accept    = 1'b0;
      cmd.emit_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               if (sts.frame_good) begin
                  state_in = ST_EMIT;
               end else if (sts.frame_bad) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit_load = 1'b1;
               rsp_valid_in  = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/bfrc_datapath.sv -----
// Datapath: frame parser state, CRC, timeout, frame store and result register.
`timescale 1ns / 1ps

module bfrc_datapath
   import bfrc_pkg::*;
#(
   parameter int PAYLOAD_MAX = 15
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic                 in_func,
   input  logic [BYTE_W-1:0]    in_rx_byte,
   input  logic                 in_ninth_bit,
   input  bfrc_cmd_type         cmd,
   output bfrc_sts_type         sts,
   output logic [BYTE_W-1:0]    out_data_byte,
   output logic [COUNT_W-1:0]   out_byte_index,
   output logic                 out_last_byte,
   output logic                 out_frame_ok,
   output logic                 out_send_ack,
   output logic                 out_group_addressed,
   output logic [BYTE_W-1:0]    out_group_id
);

   localparam int STORE_DEPTH = PAYLOAD_MAX + 3;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Configuration
   logic [BYTE_W-1:0] own_id_ff, group_mask_ff, timeout_ticks_ff;

   // Parser state
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0]  attr_ff, attr_in;
   logic               addressed_ff, addressed_in;
   logic               tmo_armed_ff, tmo_armed_in;
   logic [BYTE_W-1:0]  tmo_count_ff, tmo_count_in;
   logic               group_hit_ff, group_hit_in;
   logic [BYTE_W-1:0]  group_value_ff, group_value_in;
   logic [COUNT_W-1:0] emit_idx_ff, emit_idx_in;

   // Frame store
   logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];
   logic               store_we;
   logic [COUNT_W-1:0] store_addr;

   // Result register
   logic [BYTE_W-1:0]  data_ff;
   logic [COUNT_W-1:0] index_ff;
   logic               last_ff, ok_ff, ack_ff, grp_ff;
   logic [BYTE_W-1:0]  gid_ff;

   logic [LEN_W-1:0]   nibble, len;
   logic [COUNT_W-1:0] crc_pos, last_idx;
   logic               active, at_crc;
   logic [BYTE_W-1:0]  tick_next, crc_step_val;
   logic               group_ok;
   logic [2:0]         group_sel;

   assign nibble   = attr_ff[LEN_W-1:0] & ATTR_LEN_MASK[LEN_W-1:0];
   assign len      = (nibble > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : nibble;
   assign crc_pos  = COUNT_W'(len) + HDR_BYTES;
   assign last_idx = COUNT_W'(len) + STORE_SKIP;

   assign active       = !in_func && (addressed_ff || in_ninth_bit);
   assign at_crc       = (byte_count_ff >= crc_pos);
   assign tick_next    = tmo_count_ff + 8'd1;
   assign crc_step_val = crc8_step(crc_ff, in_rx_byte);
   assign group_sel    = 3'(in_rx_byte - 8'd1);
   assign group_ok     = (in_rx_byte != '0) && (in_rx_byte <= GROUP_ID_MAX)
                         && group_mask_ff[group_sel];

   assign sts.frame_good = active && at_crc && (in_rx_byte == crc_ff);
   assign sts.frame_bad  = active && at_crc && (in_rx_byte != crc_ff);
   assign sts.emit_last  = (emit_idx_ff == last_idx);

   always_comb begin
      byte_count_in  = byte_count_ff;
      crc_in         = crc_ff;
      attr_in        = attr_ff;
      addressed_in   = addressed_ff;
      tmo_armed_in   = tmo_armed_ff;
      tmo_count_in   = tmo_count_ff;
      group_hit_in   = group_hit_ff;
      group_value_in = group_value_ff;
      emit_idx_in    = emit_idx_ff;
      store_we       = 1'b0;
      store_addr     = byte_count_ff;

      if (cmd.emit_load) begin
         emit_idx_in = emit_idx_ff + 5'd1;
      end

      if (cmd.accept) begin
         if (in_func) begin
            // Timer tick: count while armed, abandon the frame on expiry
            if (tmo_armed_ff) begin
               tmo_count_in = tick_next;
               if (tick_next == timeout_ticks_ff) begin
                  tmo_armed_in   = 1'b0;
                  tmo_count_in   = '0;
                  byte_count_in  = '0;
                  crc_in         = '0;
                  addressed_in   = 1'b0;
                  group_hit_in   = 1'b0;
                  group_value_in = '0;
               end
            end
         end else if (active) begin
            // An active byte restarts the timeout; taking it re-arms it unless the frame closes or is dropped
            tmo_armed_in  = 1'b1;
            tmo_count_in  = '0;
            byte_count_in = byte_count_ff + 5'd1;
            crc_in        = crc_step_val;
            if (byte_count_ff < POS_ATTR) begin
               store_we = 1'b1;
            end else if (byte_count_ff == POS_ATTR) begin
               if ((in_rx_byte & ATTR_KIND_MASK) != ATTR_FEEDBACK) begin
                  store_we = 1'b1;
                  attr_in  = in_rx_byte;
               end else begin
                  tmo_armed_in   = 1'b0;
                  byte_count_in  = '0;
                  crc_in         = '0;
                  addressed_in   = 1'b0;
                  group_hit_in   = 1'b0;
                  group_value_in = '0;
               end
            end else if (byte_count_ff == POS_CRC_ONLY) begin
               // only enters the CRC
            end else if (byte_count_ff == POS_DEST) begin
               if ((attr_ff & ATTR_GROUP_BIT) != '0) begin
                  group_hit_in   = group_ok;
                  group_value_in = group_ok ? in_rx_byte : '0;
                  addressed_in   = group_ok;
               end else begin
                  group_hit_in   = 1'b0;
                  group_value_in = '0;
                  addressed_in   = (in_rx_byte == own_id_ff) || (in_rx_byte == BROADCAST_ID);
               end
               if (!addressed_in) begin
                  tmo_armed_in  = 1'b0;
                  byte_count_in = '0;
                  crc_in        = '0;
               end
            end else if (!at_crc) begin
               store_we   = 1'b1;
               store_addr = byte_count_ff - STORE_SKIP;
            end else begin
               // CRC byte closes the frame either way
               tmo_armed_in   = 1'b0;
               byte_count_in  = '0;
               crc_in         = '0;
               addressed_in   = 1'b0;
               group_hit_in   = 1'b0;
               group_value_in = '0;
               emit_idx_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff        <= OWN_ID_RST;
         group_mask_ff    <= GROUP_MASK_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
         byte_count_ff    <= '0;
         crc_ff           <= '0;
         attr_ff          <= '0;
         addressed_ff     <= 1'b0;
         tmo_armed_ff     <= 1'b0;
         tmo_count_ff     <= '0;
         group_hit_ff     <= 1'b0;
         group_value_ff   <= '0;
         emit_idx_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_OWN_ID:        own_id_ff        <= csr_wdata;
               CSR_GROUP_MASK:    group_mask_ff    <= csr_wdata;
               CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
         byte_count_ff  <= byte_count_in;
         crc_ff         <= crc_in;
         attr_ff        <= attr_in;
         addressed_ff   <= addressed_in;
         tmo_armed_ff   <= tmo_armed_in;
         tmo_count_ff   <= tmo_count_in;
         group_hit_ff   <= group_hit_in;
         group_value_ff <= group_value_in;
         emit_idx_ff    <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_addr[ADDR_W-1:0]] <= in_rx_byte;
      end
   end

   // Result register; the stored byte is read straight into it
   always_ff @(posedge clock) begin
      if (cmd.accept && sts.frame_good) begin
         ok_ff  <= 1'b1;
         grp_ff <= group_hit_ff;
         gid_ff <= group_hit_ff ? group_value_ff : '0;
      end else if (cmd.accept && sts.frame_bad) begin
         data_ff  <= '0;
         index_ff <= '0;
         last_ff  <= 1'b1;
         ok_ff    <= 1'b0;
         ack_ff   <= 1'b0;
         grp_ff   <= 1'b0;
         gid_ff   <= '0;
      end else if (cmd.emit_load) begin
         data_ff  <= store_mem[emit_idx_ff[ADDR_W-1:0]];
         index_ff <= emit_idx_ff;
         last_ff  <= sts.emit_last;
         ack_ff   <= sts.emit_last;
      end
   end

   assign out_data_byte       = data_ff;
   assign out_byte_index      = index_ff;
   assign out_last_byte       = last_ff;
   assign out_frame_ok        = ok_ff;
   assign out_send_ack        = ack_ff;
   assign out_group_addressed = grp_ff;
   assign out_group_id        = gid_ff;

endmodule
